[src/orl_pkg.sv]
// orl_pkg: shared types and codes of the ordered record list
// operation and status codes, record layout, controller states and the
// command and status bundles between controller and datapath
package orl_pkg;

   localparam int POS_W   = 6;
   localparam int COUNT_W = 6;

   typedef enum logic [2:0] {
      FN_INS_FRONT,
      FN_INS_REAR,
      FN_INS_POS,
      FN_INS_SORTED,
      FN_DEL_FRONT,
      FN_DEL_REAR,
      FN_DEL_POS,
      FN_READ
   } func_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_FULL,
      ST_EMPTY,
      ST_BADPOS
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_SEARCH,
      S_SHIFT_UP,
      S_SHIFT_DN,
      S_READ_WAIT,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {
      TGT_ZERO,
      TGT_COUNT,
      TGT_REQ,
      TGT_SCAN
   } tgt_sel_type;

   typedef struct packed {
      logic [7:0]  age;
      logic [15:0] ident;
      logic [3:0]  month;
      logic [11:0] year;
   } rec_type;

   localparam int REC_W = $bits(rec_type);

   typedef struct packed {
      logic        load;
      logic        tgt_load;
      tgt_sel_type tgt_sel;
      logic        init_scan;
      logic        scan_step;
      logic        init_up;
      logic        init_dn;
      logic        shift_up;
      logic        shift_dn;
      logic        read_issue;
      logic        read_capture;
      logic        cnt_inc;
      logic        cnt_dec;
      logic        finish;
      status_type  status;
   } ctrl_cmd_type;

   typedef struct packed {
      func_type func;
      logic     full;
      logic     empty;
      logic     pos_gt;
      logic     pos_ge;
      logic     scan_done;
      logic     up_done;
      logic     dn_done;
   } dp_stat_type;

endpackage

[src/orl_if.sv]
// orl_req_if, orl_rsp_if: valid/ready channels of the ordered record list
// request carries one operation, response carries its status and read record
interface orl_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  func;
   logic [5:0]  position;
   logic [7:0]  age;
   logic [15:0] ident;
   logic [3:0]  birth_month;
   logic [11:0] birth_year;

   modport source (output valid, func, position, age, ident, birth_month, birth_year,
                   input ready);
   modport sink (input valid, func, position, age, ident, birth_month, birth_year,
                 output ready);
endinterface

interface orl_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [5:0]  entry_count;
   logic [7:0]  read_age;
   logic [15:0] read_ident;
   logic [3:0]  read_month;
   logic [11:0] read_year;

   modport source (output valid, status, entry_count, read_age, read_ident, read_month,
                   read_year, input ready);
   modport sink (input valid, status, entry_count, read_age, read_ident, read_month,
                 read_year, output ready);
endinterface

[src/ordered_record_list.sv]
// ordered_record_list: bounded contiguous list of records with sorted insert
// steps: decode, then a key scan for sorted insert, a shift loop for insert and most
// deletes, or a read wait for read; refused ops and rear delete go straight to done,
// which hands the result to the registered response once the slot is free
// throughput: one item at a time, bounded by the one-entry-per-cycle ram shift loop
// reset: synchronous, clears the count and the handshake state; store is not cleared
module ordered_record_list import orl_pkg::*; #(
   parameter int CAPACITY = 32
) (
   input  logic     clock,
   input  logic     reset,
   orl_req_if.sink  req_ch,
   orl_rsp_if.source rsp_ch
);

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   orl_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_ch.valid),
      .req_ready(req_ch.ready),
      .rsp_valid(rsp_ch.valid),
      .rsp_ready(rsp_ch.ready),
      .stat(stat),
      .cmd(cmd)
   );

   orl_datapath #(
      .CAPACITY(CAPACITY)
   ) u_datapath (
      .clock(clock),
      .reset(reset),
      .req_func(req_ch.func),
      .req_position(req_ch.position),
      .req_age(req_ch.age),
      .req_ident(req_ch.ident),
      .req_birth_month(req_ch.birth_month),
      .req_birth_year(req_ch.birth_year),
      .cmd(cmd),
      .stat(stat),
      .rsp_status(rsp_ch.status),
      .rsp_entry_count(rsp_ch.entry_count),
      .rsp_read_age(rsp_ch.read_age),
      .rsp_read_ident(rsp_ch.read_ident),
      .rsp_read_month(rsp_ch.read_month),
      .rsp_read_year(rsp_ch.read_year)
   );

endmodule

[src/orl_ram.sv]
// orl_ram: generic single write port, single read port ram
// registered read data, no dependencies
module orl_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

[src/orl_datapath.sv]
// orl_datapath: record store, count, shift and scan pointers, result register
// depends on orl_pkg and orl_ram; driven by orl_ctrl commands
module orl_datapath import orl_pkg::*; #(
   parameter int CAPACITY = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic [2:0]   req_func,
   input  logic [5:0]   req_position,
   input  logic [7:0]   req_age,
   input  logic [15:0]  req_ident,
   input  logic [3:0]   req_birth_month,
   input  logic [11:0]  req_birth_year,
   input  ctrl_cmd_type cmd,
   output dp_stat_type  stat,
   output logic [1:0]   rsp_status,
   output logic [5:0]   rsp_entry_count,
   output logic [7:0]   rsp_read_age,
   output logic [15:0]  rsp_read_ident,
   output logic [3:0]   rsp_read_month,
   output logic [11:0]  rsp_read_year
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (CW > POS_W) ? CW : POS_W;

   func_type             func_ff, func_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   rec_type              rec_ff, rec_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [CW-1:0]        tgt_ff, tgt_in;
   logic [CW-1:0]        k_ff, k_in;
   logic                 wpend_ff, wpend_in;
   logic [AW-1:0]        waddr_ff, waddr_in;
   logic                 rdv_ff, rdv_in;
   rec_type              rd_rec_ff, rd_rec_in;
   status_type           out_status_ff, out_status_in;
   logic [COUNT_W-1:0]   out_count_ff, out_count_in;
   rec_type              out_rec_ff, out_rec_in;

   logic                 ram_we;
   logic [AW-1:0]        ram_waddr;
   rec_type              ram_wdata;
   logic                 ram_re;
   logic [AW-1:0]        ram_raddr;
   logic [REC_W-1:0]     ram_rdata;
   rec_type              rd_data;

   logic [XW-1:0]        pos_x;
   logic [XW-1:0]        cnt_x;
   logic [CW-1:0]        tgt_val;
   logic                 scan_hit;
   logic [CW-1:0]        scan_pos;

   orl_ram #(
      .WIDTH(REC_W),
      .DEPTH(CAPACITY)
   ) u_ram (
      .clock(clock),
      .we(ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .re(ram_re),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   assign rd_data = rec_type'(ram_rdata);
   assign pos_x   = XW'(pos_ff);
   assign cnt_x   = XW'(cnt_ff);

   // first entry with a larger key ends the scan, else the scan runs to the count
   assign scan_hit = rdv_ff && (rd_data.age > rec_ff.age);
   assign scan_pos = scan_hit ? (k_ff - CW'(1)) : k_ff;

   always_comb begin
      case (cmd.tgt_sel)
         TGT_ZERO:  tgt_val = '0;
         TGT_COUNT: tgt_val = cnt_ff;
         TGT_REQ:   tgt_val = CW'(pos_x);
         TGT_SCAN:  tgt_val = scan_pos;
         default:   tgt_val = '0;
      endcase
   end

   always_comb begin
      stat.func      = func_ff;
      stat.full      = (cnt_ff == CW'(CAPACITY));
      stat.empty     = (cnt_ff == '0);
      stat.pos_gt    = (pos_x > cnt_x);
      stat.pos_ge    = (pos_x >= cnt_x);
      stat.scan_done = scan_hit || (k_ff == cnt_ff);
      stat.up_done   = !wpend_ff && (k_ff == tgt_ff);
      stat.dn_done   = !wpend_ff && (k_ff >= cnt_ff);
   end

   always_comb begin
      func_in       = func_ff;
      pos_in        = pos_ff;
      rec_in        = rec_ff;
      cnt_in        = cnt_ff;
      tgt_in        = tgt_ff;
      k_in          = k_ff;
      wpend_in      = wpend_ff;
      waddr_in      = waddr_ff;
      rdv_in        = rdv_ff;
      rd_rec_in     = rd_rec_ff;
      out_status_in = out_status_ff;
      out_count_in  = out_count_ff;
      out_rec_in    = out_rec_ff;
      ram_we        = 1'b0;
      ram_waddr     = AW'(tgt_ff);
      ram_wdata     = rec_ff;
      ram_re        = 1'b0;
      ram_raddr     = AW'(k_ff);

      if (cmd.load) begin
         func_in     = func_type'(req_func);
         pos_in      = req_position;
         rec_in.age   = req_age;
         rec_in.ident = req_ident;
         rec_in.month = req_birth_month;
         rec_in.year  = req_birth_year;
         rd_rec_in   = '0;
      end

      if (cmd.tgt_load) begin
         tgt_in = tgt_val;
      end

      if (cmd.init_scan) begin
         k_in   = '0;
         rdv_in = 1'b0;
      end

      if (cmd.scan_step) begin
         ram_re    = 1'b1;
         ram_raddr = AW'(k_ff);
         k_in      = k_ff + CW'(1);
         rdv_in    = 1'b1;
      end

      if (cmd.init_up) begin
         k_in     = cnt_ff;
         wpend_in = 1'b0;
      end

      if (cmd.init_dn) begin
         k_in     = tgt_val + CW'(1);
         wpend_in = 1'b0;
      end

      // open a slot: move entry k-1 to k, walking down to the target
      if (cmd.shift_up) begin
         if (wpend_ff) begin
            ram_we    = 1'b1;
            ram_waddr = waddr_ff;
            ram_wdata = rd_data;
         end else if (k_ff == tgt_ff) begin
            ram_we    = 1'b1;
            ram_waddr = AW'(tgt_ff);
            ram_wdata = rec_ff;
         end
         if (k_ff > tgt_ff) begin
            ram_re    = 1'b1;
            ram_raddr = AW'(k_ff - CW'(1));
            wpend_in  = 1'b1;
            waddr_in  = AW'(k_ff);
            k_in      = k_ff - CW'(1);
         end else begin
            wpend_in = 1'b0;
         end
      end

      // close a slot: move entry k to k-1, walking up to the count
      if (cmd.shift_dn) begin
         if (wpend_ff) begin
            ram_we    = 1'b1;
            ram_waddr = waddr_ff;
            ram_wdata = rd_data;
         end
         if (k_ff < cnt_ff) begin
            ram_re    = 1'b1;
            ram_raddr = AW'(k_ff);
            wpend_in  = 1'b1;
            waddr_in  = AW'(k_ff - CW'(1));
            k_in      = k_ff + CW'(1);
         end else begin
            wpend_in = 1'b0;
         end
      end

      if (cmd.read_issue) begin
         ram_re    = 1'b1;
         ram_raddr = AW'(tgt_val);
      end

      if (cmd.read_capture) begin
         rd_rec_in = rd_data;
      end

      if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (cmd.cnt_dec) begin
         cnt_in = cnt_ff - CW'(1);
      end

      if (cmd.finish) begin
         out_status_in = cmd.status;
         out_count_in  = COUNT_W'(cnt_ff);
         out_rec_in    = rd_rec_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         wpend_ff <= 1'b0;
         rdv_ff   <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         wpend_ff <= wpend_in;
         rdv_ff   <= rdv_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      pos_ff        <= pos_in;
      rec_ff        <= rec_in;
      tgt_ff        <= tgt_in;
      k_ff          <= k_in;
      waddr_ff      <= waddr_in;
      rd_rec_ff     <= rd_rec_in;
      out_status_ff <= out_status_in;
      out_count_ff  <= out_count_in;
      out_rec_ff    <= out_rec_in;
   end

   assign rsp_status      = out_status_ff;
   assign rsp_entry_count = out_count_ff;
   assign rsp_read_age    = out_rec_ff.age;
   assign rsp_read_ident  = out_rec_ff.ident;
   assign rsp_read_month  = out_rec_ff.month;
   assign rsp_read_year   = out_rec_ff.year;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(CAPACITY))
      else $error("record count above capacity");

   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (cnt_ff != $past(cnt_ff))) |->
         ((cnt_ff == $past(cnt_ff) + CW'(1)) || (cnt_ff == $past(cnt_ff) - CW'(1))))
      else $error("record count moved by more than one");

   a_scan_no_write: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_step |-> !ram_we)
      else $error("store written during sorted scan");

endmodule

[src/orl_ctrl.sv]
// orl_ctrl: operation sequencer and response handshake of the ordered record list
// depends on orl_pkg; commands orl_datapath and reads back its status bundle
module orl_ctrl import orl_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  dp_stat_type  stat,
   output ctrl_cmd_type cmd
);

   state_type  state_ff, state_in;
   status_type status_ff, status_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
   end

   always_comb begin
      state_in  = state_ff;
      status_in = status_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.tgt_sel = TGT_ZERO;
      cmd.status  = status_ff;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load  = 1'b1;
               status_in = ST_OK;
               state_in  = S_DECODE;
            end
         end

         S_DECODE: begin
            case (stat.func)
               FN_INS_FRONT, FN_INS_REAR, FN_INS_POS, FN_INS_SORTED: begin
                  if (stat.full) begin
                     status_in = ST_FULL;
                     state_in  = S_DONE;
                  end else begin
                     case (stat.func)
                        FN_INS_FRONT: begin
                           cmd.tgt_sel  = TGT_ZERO;
                           cmd.tgt_load = 1'b1;
                           cmd.init_up  = 1'b1;
                           state_in     = S_SHIFT_UP;
                        end
                        FN_INS_REAR: begin
                           cmd.tgt_sel  = TGT_COUNT;
                           cmd.tgt_load = 1'b1;
                           cmd.init_up  = 1'b1;
                           state_in     = S_SHIFT_UP;
                        end
                        FN_INS_POS: begin
                           if (stat.pos_gt) begin
                              status_in = ST_BADPOS;
                              state_in  = S_DONE;
                           end else begin
                              cmd.tgt_sel  = TGT_REQ;
                              cmd.tgt_load = 1'b1;
                              cmd.init_up  = 1'b1;
                              state_in     = S_SHIFT_UP;
                           end
                        end
                        default: begin
                           cmd.init_scan = 1'b1;
                           state_in      = S_SEARCH;
                        end
                     endcase
                  end
               end
               default: begin
                  if (stat.empty) begin
                     status_in = ST_EMPTY;
                     state_in  = S_DONE;
                  end else if (stat.func == FN_DEL_FRONT) begin
                     cmd.tgt_sel  = TGT_ZERO;
                     cmd.tgt_load = 1'b1;
                     cmd.init_dn  = 1'b1;
                     state_in     = S_SHIFT_DN;
                  end else if (stat.func == FN_DEL_REAR) begin
                     cmd.cnt_dec = 1'b1;
                     state_in    = S_DONE;
                  end else if (stat.pos_ge) begin
                     status_in = ST_BADPOS;
                     state_in  = S_DONE;
                  end else if (stat.func == FN_DEL_POS) begin
                     cmd.tgt_sel  = TGT_REQ;
                     cmd.tgt_load = 1'b1;
                     cmd.init_dn  = 1'b1;
                     state_in     = S_SHIFT_DN;
                  end else begin
                     cmd.tgt_sel    = TGT_REQ;
                     cmd.tgt_load   = 1'b1;
                     cmd.read_issue = 1'b1;
                     state_in       = S_READ_WAIT;
                  end
               end
            endcase
         end

         S_SEARCH: begin
            if (stat.scan_done) begin
               cmd.tgt_sel  = TGT_SCAN;
               cmd.tgt_load = 1'b1;
               cmd.init_up  = 1'b1;
               state_in     = S_SHIFT_UP;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end

         S_SHIFT_UP: begin
            cmd.shift_up = 1'b1;
            if (stat.up_done) begin
               cmd.cnt_inc = 1'b1;
               state_in    = S_DONE;
            end
         end

         S_SHIFT_DN: begin
            cmd.shift_dn = 1'b1;
            if (stat.dn_done) begin
               cmd.cnt_dec = 1'b1;
               state_in    = S_DONE;
            end
         end

         S_READ_WAIT: begin
            cmd.read_capture = 1'b1;
            state_in         = S_DONE;
         end

         S_DONE: begin
            // result register frees up in the same cycle it is taken
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_finish_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("finished item not presented");

   a_shift_ok: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_SHIFT_UP) || (state_ff == S_SHIFT_DN) || (state_ff == S_SEARCH))
         |-> (status_ff == ST_OK))
      else $error("refused item reached a shift");

endmodule

[verif/ordered_record_list_tb.sv]
// ordered_record_list_tb: self-checking bench for the ordered record list
// drives ops over orl_req_if, checks each status/count/read item against a queue-based
// shadow of the list or a directed row's item; needs orl_pkg, orl_if, ordered_record_list
module ordered_record_list_tb;
   import orl_pkg::*;

   localparam int CAPACITY       = 32;
   localparam int ITEM_TARGET    = 1900;
   localparam int LONG_HOLD      = 400;
   localparam int TAIL_CYCLES    = 2 * CAPACITY + 16;
   localparam int WATCHDOG_LIMIT = 3000;

   typedef enum int {
      MODE_MIXED,
      MODE_FILL,
      MODE_DRAIN,
      MODE_SORTED
   } mode_type;

   typedef struct {
      func_type   func;
      logic [5:0] pos;
      rec_type    rec;
   } list_op_type;

   typedef struct {
      status_type status;
      logic [5:0] count;
      rec_type    rd;
   } list_result_type;

   typedef struct {
      list_op_type     op;
      bit              typed;
      list_result_type want;
   } dir_row_type;

   logic clock;
   logic reset;

   orl_req_if req_ch ();
   orl_rsp_if rsp_ch ();

   ordered_record_list #(.CAPACITY(CAPACITY)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   rec_type         shadow_list[$];
   list_result_type rsp_due[$];
   dir_row_type     dir_table[$];
   int              mismatches = 0;
   int              items_sent;
   int              idle_cycles;
   bit              calm;
   int              hold_reqs;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // list contents after one op, and the item the block should return for it
   function automatic list_result_type list_apply(list_op_type op);
      list_result_type res;
      int slot;
      res.status = ST_OK;
      res.rd     = '0;
      slot       = 0;
      case (op.func)
         FN_INS_FRONT, FN_INS_REAR, FN_INS_POS, FN_INS_SORTED: begin
            if (shadow_list.size() >= CAPACITY) begin
               res.status = ST_FULL;
            end else if (op.func == FN_INS_POS && int'(op.pos) > shadow_list.size()) begin
               res.status = ST_BADPOS;
            end else begin
               case (op.func)
                  FN_INS_FRONT: slot = 0;
                  FN_INS_REAR:  slot = shadow_list.size();
                  FN_INS_POS:   slot = int'(op.pos);
                  default: begin
                     // stable: lands after every entry with an equal key
                     while (slot < shadow_list.size() && shadow_list[slot].age <= op.rec.age)
                        slot++;
                  end
               endcase
               shadow_list.insert(slot, op.rec);
            end
         end
         default: begin
            if (shadow_list.size() == 0) begin
               res.status = ST_EMPTY;
            end else if (op.func == FN_DEL_FRONT) begin
               void'(shadow_list.pop_front());
            end else if (op.func == FN_DEL_REAR) begin
               void'(shadow_list.pop_back());
            end else if (int'(op.pos) >= shadow_list.size()) begin
               res.status = ST_BADPOS;
            end else if (op.func == FN_DEL_POS) begin
               shadow_list.delete(int'(op.pos));
            end else begin
               res.rd = shadow_list[op.pos];
            end
         end
      endcase
      res.count = 6'(shadow_list.size());
      return res;
   endfunction

   function automatic int pick_gap();
      int r;
      if (calm)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 88)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic list_op_type random_op(mode_type mode);
      list_op_type op;
      int r;
      int n;
      n = shadow_list.size();
      r = $urandom_range(0, 99);
      case (mode)
         MODE_FILL:
            op.func = (r < 85) ? func_type'($urandom_range(0, 3))
                               : func_type'($urandom_range(4, 7));
         MODE_DRAIN:
            op.func = (r < 85) ? func_type'($urandom_range(4, 6))
                               : func_type'($urandom_range(0, 7));
         MODE_SORTED:
            op.func = (r < 70) ? FN_INS_SORTED : FN_READ;
         default:
            op.func = func_type'($urandom_range(0, 7));
      endcase
      r = $urandom_range(0, 99);
      if (r < 15)
         op.pos = 6'($urandom_range(0, 63));
      else if (r < 30)
         op.pos = 6'(n + int'($urandom_range(0, 1)));
      else if (op.func == FN_INS_POS || n == 0)
         op.pos = 6'($urandom_range(0, n));
      else
         op.pos = 6'($urandom_range(0, n - 1));
      // a narrow key range half the time so sorted inserts meet equal keys
      op.rec.age   = $urandom_range(0, 1) ? 8'($urandom_range(0, 15))
                                          : 8'($urandom_range(0, 255));
      op.rec.ident = 16'($urandom);
      op.rec.month = 4'($urandom);
      op.rec.year  = 12'($urandom);
      return op;
   endfunction

   function automatic dir_row_type row(func_type f, int pos, rec_type rec, bit typed,
                                       status_type st, int cnt, rec_type rd);
      dir_row_type d;
      d.op.func     = f;
      d.op.pos      = 6'(pos);
      d.op.rec      = rec;
      d.typed       = typed;
      d.want.status = st;
      d.want.count  = 6'(cnt);
      d.want.rd     = rd;
      return d;
   endfunction

   // enter and leave at a falling edge; valid is left high after the item is taken
   task automatic offer(list_op_type op, bit typed, list_result_type want);
      int gap;
      list_result_type res;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.func        = op.func;
      req_ch.position    = op.pos;
      req_ch.age         = op.rec.age;
      req_ch.ident       = op.rec.ident;
      req_ch.birth_month = op.rec.month;
      req_ch.birth_year  = op.rec.year;
      req_ch.valid       = 1'b1;
      do
         @(posedge clock);
      while (!req_ch.ready);
      res = list_apply(op);
      rsp_due.push_back(typed ? want : res);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic check_field(string what, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      list_result_type exp_rsp;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (rsp_due.size() == 0) begin
            $display("%0t: unexpected item, status %0d count %0d", $time,
                     rsp_ch.status, rsp_ch.entry_count);
            mismatches++;
         end else begin
            exp_rsp = rsp_due.pop_front();
            check_field("status", 16'(exp_rsp.status), 16'(rsp_ch.status));
            check_field("entry_count", 16'(exp_rsp.count), 16'(rsp_ch.entry_count));
            check_field("read_age", 16'(exp_rsp.rd.age), 16'(rsp_ch.read_age));
            check_field("read_ident", exp_rsp.rd.ident, rsp_ch.read_ident);
            check_field("read_month", 16'(exp_rsp.rd.month), 16'(rsp_ch.read_month));
            check_field("read_year", 16'(exp_rsp.rd.year), 16'(rsp_ch.read_year));
         end
      end
   end

   // receiver: random stalls, plus a long hold on request
   initial begin
      int stall_left;
      int holds_done;
      stall_left   = 0;
      holds_done   = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_reqs != holds_done) begin
            rsp_ch.ready = 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            holds_done = hold_reqs;
         end
         if (stall_left > 0) begin
            rsp_ch.ready = 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready = 1'b1;
            if ($urandom_range(0, 3) == 0)
               stall_left = pick_gap();
         end
      end
   end

   initial begin
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Verification failed");
      $finish;
   end

   initial begin
      list_op_type     op;
      list_result_type none;
      rec_type         rec_max;
      rec_type         rec_zero;
      rec_type         rec_mid;
      mode_type        mode;
      int              episode;
      int              run_len;

      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.func        = FN_INS_FRONT;
      req_ch.position    = '0;
      req_ch.age         = '0;
      req_ch.ident       = '0;
      req_ch.birth_month = '0;
      req_ch.birth_year  = '0;
      items_sent         = 0;
      calm               = 1'b0;
      hold_reqs          = 0;
      none               = '{ST_OK, '0, '0};
      rec_max            = '1;
      rec_zero           = '0;
      rec_mid            = '{age: 8'd128, ident: 16'h1234, month: 4'd6, year: 12'd2000};

      // empty checks come before position checks, full before position
      dir_table.push_back(row(FN_READ,       0,  rec_zero, 1, ST_EMPTY,  0, rec_zero));
      dir_table.push_back(row(FN_DEL_FRONT,  0,  rec_zero, 1, ST_EMPTY,  0, rec_zero));
      dir_table.push_back(row(FN_DEL_REAR,   0,  rec_zero, 1, ST_EMPTY,  0, rec_zero));
      dir_table.push_back(row(FN_DEL_POS,    63, rec_zero, 1, ST_EMPTY,  0, rec_zero));
      dir_table.push_back(row(FN_INS_POS,    1,  rec_max,  1, ST_BADPOS, 0, rec_zero));
      dir_table.push_back(row(FN_INS_POS,    0,  rec_max,  1, ST_OK,     1, rec_zero));
      dir_table.push_back(row(FN_READ,       0,  rec_zero, 1, ST_OK,     1, rec_max));
      dir_table.push_back(row(FN_READ,       1,  rec_zero, 1, ST_BADPOS, 1, rec_zero));
      dir_table.push_back(row(FN_READ,       63, rec_zero, 1, ST_BADPOS, 1, rec_zero));
      dir_table.push_back(row(FN_INS_FRONT,  0,  rec_zero, 1, ST_OK,     2, rec_zero));
      dir_table.push_back(row(FN_READ,       0,  rec_max,  1, ST_OK,     2, rec_zero));
      dir_table.push_back(row(FN_INS_REAR,   0,  rec_mid,  0, ST_OK,     0, rec_zero));
      rec_mid.ident = 16'h0002;
      dir_table.push_back(row(FN_INS_SORTED, 0,  rec_mid,  0, ST_OK,     0, rec_zero));
      rec_mid.age = 8'd0;
      rec_mid.ident = 16'h0003;
      dir_table.push_back(row(FN_INS_SORTED, 0,  rec_mid,  0, ST_OK,     0, rec_zero));
      rec_mid.age = 8'd255;
      rec_mid.ident = 16'h0004;
      dir_table.push_back(row(FN_INS_SORTED, 0,  rec_mid,  0, ST_OK,     0, rec_zero));
      // position equal to the count appends
      dir_table.push_back(row(FN_INS_POS,    6,  rec_max,  0, ST_OK,     0, rec_zero));
      dir_table.push_back(row(FN_INS_POS,    63, rec_zero, 1, ST_BADPOS, 7, rec_zero));
      dir_table.push_back(row(FN_READ,       2,  rec_zero, 0, ST_OK,     0, rec_zero));
      dir_table.push_back(row(FN_READ,       3,  rec_zero, 0, ST_OK,     0, rec_zero));
      dir_table.push_back(row(FN_DEL_POS,    7,  rec_zero, 1, ST_BADPOS, 7, rec_zero));
      dir_table.push_back(row(FN_DEL_POS,    3,  rec_zero, 0, ST_OK,     0, rec_zero));
      dir_table.push_back(row(FN_DEL_FRONT,  0,  rec_zero, 0, ST_OK,     0, rec_zero));
      dir_table.push_back(row(FN_DEL_REAR,   0,  rec_zero, 0, ST_OK,     0, rec_zero));
      dir_table.push_back(row(FN_READ,       0,  rec_zero, 0, ST_OK,     0, rec_zero));

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_table[i])
         offer(dir_table[i].op, dir_table[i].typed, dir_table[i].want);

      episode = 0;
      while (items_sent < ITEM_TARGET) begin
         mode    = mode_type'($urandom_range(0, 3));
         run_len = $urandom_range(20, 80);
         calm    = ($urandom_range(0, 3) == 0);
         // long receiver hold while items keep coming, so the input backs up
         if (episode % 12 == 2) begin
            calm = 1'b1;
            hold_reqs++;
         end
         // the sender goes quiet until every item has come back
         if (episode % 7 == 4) begin
            req_ch.valid = 1'b0;
            while (rsp_due.size() != 0) @(negedge clock);
         end
         repeat (run_len) begin
            op = random_op(mode);
            offer(op, 1'b0, none);
         end
         episode++;
      end

      req_ch.valid = 1'b0;
      while (rsp_due.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

[files.f]
src/orl_pkg.sv
src/orl_if.sv
src/orl_ram.sv
src/orl_datapath.sv
src/orl_ctrl.sv
src/ordered_record_list.sv
verif/ordered_record_list_tb.sv
